// ===== rtl/core/set_assoc_lru_writeback_cache_tags_core_assert.svh =====
// Assertion macros for the cache tag store.
// Each macro takes a label, a clock, an active-low reset, an antecedent,
// a consequent and a message.
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_TAGS_CORE_ASSERT_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_TAGS_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SALC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SALC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/salc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// salc_pkg
// Types, constants and helpers shared by the cache tag store modules.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int NUM_SETS  = 256;
    localparam int NUM_WAYS  = 4;
    localparam int TAG_BITS  = 24;
    localparam int ADDR_W    = 32;
    localparam int SET_IN_W  = 8;
    localparam int SET_W     = $clog2(NUM_SETS);
    localparam int WAY_W     = $clog2(NUM_WAYS);
    localparam int RANK_W    = WAY_W;

    // Access kinds.
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef logic [SET_W-1:0]  t_set;
    typedef logic [WAY_W-1:0]  t_way;
    typedef logic [RANK_W-1:0] t_rank;

    typedef struct packed {
        logic                func;
        logic [SET_IN_W-1:0] set_sel;
        logic [TAG_BITS-1:0] tag;
        logic [ADDR_W-1:0]   full_address;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic              writeback;
        logic [ADDR_W-1:0] writeback_address;
    } t_rsp;

    // Replacement state of one set; this part has a defined reset value.
    typedef struct packed {
        logic [NUM_WAYS-1:0]             valid;
        logic [NUM_WAYS-1:0]             dirty;
        logic [NUM_WAYS-1:0][RANK_W-1:0] rank;
    } t_meta;

    // One set as held in the row memory.
    typedef struct packed {
        logic [NUM_WAYS-1:0][TAG_BITS-1:0] tag;
        logic [NUM_WAYS-1:0][ADDR_W-1:0]   addr;
        t_meta                             meta;
    } t_row;

    // Replacement state of a set that has never been written.
    function automatic t_meta meta_reset();
        t_meta m;
        m.valid = '0;
        m.dirty = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            m.rank[w] = RANK_W'(w);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/set_assoc_lru_writeback_cache_tags_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_tags_core
// Tag store of a 256-set, 4-way write-back, write-allocate cache with LRU.
// ----------------------------------------------------------------------------
// Each request names a set, a tag, a full address and whether it is a read or
// a write, and produces exactly one response: hit, and on a miss that evicts a
// dirty line, the writeback flag and the stored address of that line (zero
// otherwise). The edge that accepts a request also reads the whole set row
// from a single-port synchronous row memory; then, in the lookup state, the
// tag store compares all four ways, chooses the victim, updates the LRU ranks
// and dirty bits, writes the row back and loads the response register. The
// next request is accepted only once that write-back has happened, so requests
// do not overlap in the tag store, a limit set by the read-then-write use of the
// row memory. A finished response waits in its own output register, so a new
// request is taken while the previous response is still stalled; the update
// cycle only waits when that register is full and stalled. No clearing pass
// is needed after reset: one flag per set, cleared by reset, marks whether the
// row has ever been written, and a row that has not reads as all ways
// invalid, clean, with each way ranked by its own number.
// ----------------------------------------------------------------------------
`include "set_assoc_lru_writeback_cache_tags_core_assert.svh"

module set_assoc_lru_writeback_cache_tags_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_req_valid,
    output logic                o_req_stall,
    input  wire salc_pkg::t_req i_req,
    output logic                o_rsp_valid,
    input  wire                 i_rsp_stall,
    output salc_pkg::t_rsp      o_rsp
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_LOOKUP = 1'b1;

    logic r_state, n_state;
    logic r_rsp_valid, n_rsp_valid;
    salc_pkg::t_req r_req;
    salc_pkg::t_rsp r_rsp;

    // Set row memory and the per-set written flags.
    salc_pkg::t_row r_mem [salc_pkg::NUM_SETS];
    salc_pkg::t_row r_rd_row;
    logic [salc_pkg::NUM_SETS-1:0] r_set_init;
    logic r_rd_init;

    salc_pkg::t_row w_cur_row;
    salc_pkg::t_row w_new_row;
    salc_pkg::t_rsp w_rsp;
    salc_pkg::t_set w_in_set;
    salc_pkg::t_set w_req_set;
    logic w_accept;
    logic w_out_free;
    logic w_update;

    // The set index is taken modulo the number of sets.
    assign w_in_set  = i_req.set_sel[salc_pkg::SET_W-1:0];
    assign w_req_set = r_req.set_sel[salc_pkg::SET_W-1:0];

    assign o_req_stall = (r_state != ST_IDLE);
    assign w_accept    = i_req_valid && !o_req_stall;
    assign w_out_free  = !r_rsp_valid || !i_rsp_stall;
    assign w_update    = (r_state == ST_LOOKUP) && w_out_free;

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // A row that has never been written shows its reset replacement state.
    always_comb begin
        w_cur_row = r_rd_row;
        if (!r_rd_init) begin
            w_cur_row.meta = salc_pkg::meta_reset();
        end
    end

    salc_way_update u_way_update (
        .i_row (w_cur_row),
        .i_req (r_req),
        .o_row (w_new_row),
        .o_rsp (w_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid;
        if (r_rsp_valid && !i_rsp_stall) begin
            n_rsp_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (w_update) begin
                    n_state     = ST_IDLE;
                    n_rsp_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rsp_valid <= 1'b0;
            r_set_init  <= '0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
            if (w_update) begin
                r_set_init[w_req_set] <= 1'b1;
            end
        end
    end

    // Payload registers: request capture, row read and response.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req     <= i_req;
            r_rd_row  <= r_mem[w_in_set];
            r_rd_init <= r_set_init[w_in_set];
        end
        if (w_update) begin
            r_mem[w_req_set] <= w_new_row;
            r_rsp            <= w_rsp;
        end
    end

    // An accepted request always moves on to the lookup cycle.
    `SALC_ASSERT_NEXT(a_accept_to_lookup, i_clk, i_rst_n, w_accept, r_state == ST_LOOKUP, "accepted request did not enter lookup")
    // A lookup with a free response register completes and presents a response.
    `SALC_ASSERT_NEXT(a_update_gives_rsp, i_clk, i_rst_n, w_update, o_rsp_valid && (r_state == ST_IDLE), "lookup did not produce a response")
    // A writeback only ever comes from a miss.
    `SALC_ASSERT_SAME(a_wb_only_on_miss, i_clk, i_rst_n, o_rsp_valid && o_rsp.writeback, !o_rsp.hit, "writeback reported on a hit")
    // Without a writeback the reported address is zero.
    `SALC_ASSERT_SAME(a_clean_addr_zero, i_clk, i_rst_n, o_rsp_valid && !o_rsp.writeback, o_rsp.writeback_address == '0, "address reported without writeback")

endmodule
`default_nettype wire

// ===== rtl/core/salc_way_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// salc_way_update
// Tag compare, victim choice and LRU/dirty update for one set row.
// ----------------------------------------------------------------------------
module salc_way_update (
    input  wire salc_pkg::t_row i_row,
    input  wire salc_pkg::t_req i_req,
    output salc_pkg::t_row      o_row,
    output salc_pkg::t_rsp      o_rsp
);

    always_comb begin
        logic           hit;
        salc_pkg::t_way hit_way;
        salc_pkg::t_way victim;
        salc_pkg::t_rank largest;
        salc_pkg::t_rank hit_rank;

        hit     = 1'b0;
        hit_way = '0;
        for (int w = 0; w < salc_pkg::NUM_WAYS; w++) begin
            if (!hit && i_row.meta.valid[w] && (i_row.tag[w] == i_req.tag)) begin
                hit     = 1'b1;
                hit_way = salc_pkg::WAY_W'(w);
            end
        end

        // The last way holding the largest rank is the victim.
        victim  = '0;
        largest = i_row.meta.rank[0];
        for (int w = 0; w < salc_pkg::NUM_WAYS; w++) begin
            if (i_row.meta.rank[w] >= largest) begin
                largest = i_row.meta.rank[w];
                victim  = salc_pkg::WAY_W'(w);
            end
        end

        hit_rank = i_row.meta.rank[hit_way];
        o_row    = i_row;
        o_rsp    = '0;
        o_rsp.hit = hit;

        if (hit) begin
            for (int w = 0; w < salc_pkg::NUM_WAYS; w++) begin
                if ((salc_pkg::WAY_W'(w) != hit_way) && (i_row.meta.rank[w] < hit_rank)) begin
                    o_row.meta.rank[w] = i_row.meta.rank[w] + salc_pkg::t_rank'(1);
                end
            end
            o_row.meta.rank[hit_way] = '0;
            if (i_req.func == salc_pkg::FUNC_WRITE) begin
                o_row.meta.dirty[hit_way] = 1'b1;
            end
        end else begin
            for (int w = 0; w < salc_pkg::NUM_WAYS; w++) begin
                if ((salc_pkg::WAY_W'(w) != victim) &&
                    (i_row.meta.rank[w] < salc_pkg::RANK_W'(salc_pkg::NUM_WAYS - 1))) begin
                    o_row.meta.rank[w] = i_row.meta.rank[w] + salc_pkg::t_rank'(1);
                end
            end
            o_row.meta.rank[victim] = '0;
            o_rsp.writeback = i_row.meta.dirty[victim];
            if (i_row.meta.dirty[victim]) begin
                o_rsp.writeback_address = i_row.addr[victim];
            end
            o_row.meta.dirty[victim] = (i_req.func == salc_pkg::FUNC_WRITE);
            o_row.meta.valid[victim] = 1'b1;
            o_row.tag[victim]        = i_req.tag;
            o_row.addr[victim]       = i_req.full_address;
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb_set_assoc_lru_writeback_cache_tags_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_writeback_cache_tags_core
// Self-checking bench for the set-associative write-back cache tag store.
// ----------------------------------------------------------------------------
// A short table of directed requests fills and overflows the first and last
// sets. It covers read and write hits and misses, dirty and clean evictions,
// and all-zero and all-one tags and addresses. A long random run follows. It
// mostly cycles a few tags through a few sets so that hits, evictions and
// writebacks are frequent, with fully random requests mixed in. Every
// response is compared field by field with the hand-written value or with a
// behavioural model of the tag store kept alongside the device.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_writeback_cache_tags_core;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_REQS  = 1700;
    localparam int MAX_GAP      = 10;
    localparam int LONG_HOLD    = 250;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_AT      = 600;
    localparam int PAUSE_AT     = 1200;
    localparam int BURST_EVERY  = 150;
    localparam int TIMEOUT_CYC  = 400000;

    // One row of the directed table. Where known is set, the response is
    // obvious from the state of the set and is written in by hand.
    typedef struct {
        salc_pkg::t_req req;
        bit             known;
        salc_pkg::t_rsp rsp;
    } t_vec;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_req_valid;
    logic           o_req_stall;
    salc_pkg::t_req i_req;
    logic           o_rsp_valid;
    logic           i_rsp_stall;
    salc_pkg::t_rsp o_rsp;

    // Shadow copy of the tag store.
    logic [salc_pkg::TAG_BITS-1:0] line_tag   [salc_pkg::NUM_SETS][salc_pkg::NUM_WAYS];
    logic [salc_pkg::ADDR_W-1:0]   line_addr  [salc_pkg::NUM_SETS][salc_pkg::NUM_WAYS];
    logic                          line_valid [salc_pkg::NUM_SETS][salc_pkg::NUM_WAYS];
    logic                          line_dirty [salc_pkg::NUM_SETS][salc_pkg::NUM_WAYS];
    salc_pkg::t_rank               line_rank  [salc_pkg::NUM_SETS][salc_pkg::NUM_WAYS];

    salc_pkg::t_rsp pending_rsp[$];
    t_vec           directed_reqs[$];

    logic [salc_pkg::SET_IN_W-1:0] set_pool [8];
    logic [salc_pkg::TAG_BITS-1:0] tag_pool [8];

    int  n_errors;
    int  n_checked;
    int  n_hits;
    int  n_writebacks;
    int  n_directed;
    int  n_random;
    bit  burst_mode;
    bit  hold_requested;

    set_assoc_lru_writeback_cache_tags_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #(CLK_PERIOD / 2) i_clk = ~i_clk;
        end
    end

    // Looks one request up in the shadow store, applies the LRU, dirty and
    // refill updates exactly as the hardware should, and returns the response.
    function automatic salc_pkg::t_rsp predict_lookup(input salc_pkg::t_req r);
        salc_pkg::t_rsp                rsp;
        int                            set_no;
        int                            hit_way;
        int                            victim;
        logic                          found;
        salc_pkg::t_rank               oldest;
        salc_pkg::t_rank               hit_rank;
        logic [salc_pkg::TAG_BITS-1:0] tag;
        rsp     = '0;
        set_no  = int'(r.set_sel) % salc_pkg::NUM_SETS;
        tag     = r.tag;
        found   = 1'b0;
        hit_way = 0;
        // The lowest matching valid way counts as the hit.
        for (int w = 0; w < salc_pkg::NUM_WAYS; w++) begin
            if (!found && line_valid[set_no][w] && line_tag[set_no][w] == tag) begin
                found   = 1'b1;
                hit_way = w;
            end
        end
        if (found) begin
            if (r.func == salc_pkg::FUNC_WRITE) begin
                line_dirty[set_no][hit_way] = 1'b1;
            end
            // Only ways that were more recent than the hit way grow older.
            hit_rank = line_rank[set_no][hit_way];
            for (int w = 0; w < salc_pkg::NUM_WAYS; w++) begin
                if (w != hit_way && line_rank[set_no][w] < hit_rank) begin
                    line_rank[set_no][w] = line_rank[set_no][w] + salc_pkg::t_rank'(1);
                end
            end
            line_rank[set_no][hit_way] = '0;
        end else begin
            // The victim is the highest-numbered way holding the largest rank.
            victim = 0;
            oldest = line_rank[set_no][0];
            for (int w = 0; w < salc_pkg::NUM_WAYS; w++) begin
                if (line_rank[set_no][w] >= oldest) begin
                    oldest = line_rank[set_no][w];
                    victim = w;
                end
            end
            for (int w = 0; w < salc_pkg::NUM_WAYS; w++) begin
                if (w != victim && line_rank[set_no][w] < salc_pkg::NUM_WAYS - 1) begin
                    line_rank[set_no][w] = line_rank[set_no][w] + salc_pkg::t_rank'(1);
                end
            end
            line_rank[set_no][victim] = '0;
            if (line_dirty[set_no][victim]) begin
                rsp.writeback         = 1'b1;
                rsp.writeback_address = line_addr[set_no][victim];
            end
            line_dirty[set_no][victim] = (r.func == salc_pkg::FUNC_WRITE);
            line_tag[set_no][victim]   = tag;
            line_addr[set_no][victim]  = r.full_address;
            line_valid[set_no][victim] = 1'b1;
        end
        rsp.hit = found;
        return rsp;
    endfunction

    task automatic add_vec(input logic func,
                           input logic [salc_pkg::SET_IN_W-1:0] set_sel,
                           input logic [salc_pkg::TAG_BITS-1:0] tag,
                           input logic [salc_pkg::ADDR_W-1:0] addr,
                           input bit known, input logic hit, input logic wb,
                           input logic [salc_pkg::ADDR_W-1:0] wb_addr);
        t_vec v;
        v.req.func                  = func;
        v.req.set_sel               = set_sel;
        v.req.tag                   = tag;
        v.req.full_address          = addr;
        v.known                     = known;
        v.rsp.hit                   = hit;
        v.rsp.writeback             = wb;
        v.rsp.writeback_address     = wb_addr;
        directed_reqs.push_back(v);
    endtask

    // Most random requests revisit a handful of sets with a handful of tags,
    // which keeps those sets busy with hits, refills and dirty evictions. The
    // remainder are fully random and exercise every bit of every field.
    function automatic salc_pkg::t_req random_req();
        salc_pkg::t_req r;
        r.func         = $urandom_range(0, 1) ? salc_pkg::FUNC_WRITE : salc_pkg::FUNC_READ;
        r.full_address = $urandom();
        if ($urandom_range(0, 99) < 85) begin
            r.set_sel = set_pool[$urandom_range(0, 7)];
            r.tag     = tag_pool[$urandom_range(0, 5)];
        end else begin
            r.set_sel = salc_pkg::SET_IN_W'($urandom());
            r.tag     = salc_pkg::TAG_BITS'($urandom());
        end
        return r;
    endfunction

    // Offers one request after a random gap, holds it until the tag store
    // takes it, and then records the response it must produce. The valid line
    // is written at most once per falling edge, so back-to-back requests keep
    // it high without a glitch.
    task automatic send_req(input salc_pkg::t_req r, input bit known,
                            input salc_pkg::t_rsp typed);
        int             gap;
        salc_pkg::t_rsp predicted;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            @(negedge i_clk);
            i_req_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_req_valid <= 1'b1;
        i_req       <= r;
        do begin
            @(posedge i_clk);
        end while (o_req_stall);
        predicted = predict_lookup(r);
        pending_rsp.push_back(known ? typed : predicted);
    endtask

    // Response side: stalls for a random number of cycles before each
    // response, and once, when asked, for a long stretch so that the tag store
    // backs up and stalls its request input.
    initial begin
        salc_pkg::t_rsp exp_rsp;
        int             stall_cycles;
        wait (i_rst_n === 1'b1);
        forever begin
            stall_cycles = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_requested) begin
                hold_requested = 1'b0;
                stall_cycles   = LONG_HOLD;
            end
            repeat (stall_cycles) begin
                @(negedge i_clk);
                i_rsp_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_rsp_stall <= 1'b0;
            do begin
                @(posedge i_clk);
            end while (!o_rsp_valid);
            if (pending_rsp.size() == 0) begin
                $display("%0t: response with none expected: hit %0b wb %0b addr %08h",
                         $time, o_rsp.hit, o_rsp.writeback, o_rsp.writeback_address);
                n_errors++;
            end else begin
                exp_rsp = pending_rsp.pop_front();
                n_checked++;
                if (o_rsp.hit) n_hits++;
                if (o_rsp.writeback) n_writebacks++;
                if (o_rsp.hit !== exp_rsp.hit) begin
                    $display("%0t: hit mismatch: expected %0b, got %0b",
                             $time, exp_rsp.hit, o_rsp.hit);
                    n_errors++;
                end
                if (o_rsp.writeback !== exp_rsp.writeback) begin
                    $display("%0t: writeback mismatch: expected %0b, got %0b",
                             $time, exp_rsp.writeback, o_rsp.writeback);
                    n_errors++;
                end
                if (o_rsp.writeback_address !== exp_rsp.writeback_address) begin
                    $display("%0t: writeback_address mismatch: expected %08h, got %08h",
                             $time, exp_rsp.writeback_address, o_rsp.writeback_address);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog, set far beyond the slowest legal run.
    initial begin
        #(CLK_PERIOD * TIMEOUT_CYC);
        $display("%0t: timed out with %0d responses outstanding", $time, pending_rsp.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        salc_pkg::t_rsp none;
        salc_pkg::t_req r;
        int             wait_cycles;
        n_errors       = 0;
        n_checked      = 0;
        n_hits         = 0;
        n_writebacks   = 0;
        n_directed     = 0;
        n_random       = 0;
        burst_mode     = 1'b0;
        hold_requested = 1'b0;
        none           = '0;
        i_rst_n        = 1'b0;
        i_req_valid    = 1'b0;
        i_req          = '0;
        i_rsp_stall    = 1'b0;

        // After reset every line is invalid and clean, and each way is ranked
        // by its own number.
        for (int s = 0; s < salc_pkg::NUM_SETS; s++) begin
            for (int w = 0; w < salc_pkg::NUM_WAYS; w++) begin
                line_tag[s][w]   = '0;
                line_addr[s][w]  = '0;
                line_valid[s][w] = 1'b0;
                line_dirty[s][w] = 1'b0;
                line_rank[s][w]  = salc_pkg::RANK_W'(w);
            end
        end

        // The first and last sets are always in the pool.
        set_pool[0] = '0;
        set_pool[1] = '1;
        for (int i = 2; i < 8; i++) set_pool[i] = salc_pkg::SET_IN_W'($urandom());
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < 8; i++) tag_pool[i] = salc_pkg::TAG_BITS'($urandom());

        // Set 0: four misses fill the empty ways, with a write hit in between;
        // further misses then evict dirty and clean lines in LRU order,
        // including a dirty line whose stored address is zero.
        add_vec(salc_pkg::FUNC_READ,  8'h00, 24'h000000, 32'h0000_0000, 1, 1'b0, 1'b0, '0);
        add_vec(salc_pkg::FUNC_WRITE, 8'h00, 24'h000000, 32'h1111_1111, 1, 1'b1, 1'b0, '0);
        add_vec(salc_pkg::FUNC_WRITE, 8'h00, 24'hFFFFFF, 32'hFFFF_FFFF, 1, 1'b0, 1'b0, '0);
        add_vec(salc_pkg::FUNC_READ,  8'h00, 24'h000001, 32'h0000_0040, 1, 1'b0, 1'b0, '0);
        add_vec(salc_pkg::FUNC_WRITE, 8'h00, 24'h000002, 32'h0000_0080, 1, 1'b0, 1'b0, '0);
        add_vec(salc_pkg::FUNC_READ,  8'h00, 24'h000003, 32'h0000_00C0, 0, 1'b0, 1'b0, '0);
        add_vec(salc_pkg::FUNC_READ,  8'h00, 24'hFFFFFF, 32'h0000_0000, 0, 1'b0, 1'b0, '0);
        add_vec(salc_pkg::FUNC_READ,  8'h00, 24'h000004, 32'h0000_0100, 0, 1'b0, 1'b0, '0);
        add_vec(salc_pkg::FUNC_READ,  8'h00, 24'h000005, 32'h0000_0140, 0, 1'b0, 1'b0, '0);
        add_vec(salc_pkg::FUNC_READ,  8'h00, 24'h000006, 32'h0000_0180, 0, 1'b0, 1'b0, '0);
        add_vec(salc_pkg::FUNC_READ,  8'h00, 24'h000007, 32'h0000_01C0, 0, 1'b0, 1'b0, '0);
        // Set 255: write fills with extreme tags and addresses, then evictions.
        add_vec(salc_pkg::FUNC_WRITE, 8'hFF, 24'hFFFFFF, 32'hFFFF_FFFF, 1, 1'b0, 1'b0, '0);
        add_vec(salc_pkg::FUNC_READ,  8'hFF, 24'hFFFFFF, 32'h0000_0000, 1, 1'b1, 1'b0, '0);
        add_vec(salc_pkg::FUNC_READ,  8'hFF, 24'h000000, 32'h0000_0000, 1, 1'b0, 1'b0, '0);
        add_vec(salc_pkg::FUNC_WRITE, 8'hFF, 24'h000000, 32'hFFFF_FFFF, 1, 1'b1, 1'b0, '0);
        add_vec(salc_pkg::FUNC_WRITE, 8'hFF, 24'hAAAAAA, 32'hAAAA_AAAA, 1, 1'b0, 1'b0, '0);
        add_vec(salc_pkg::FUNC_WRITE, 8'hFF, 24'h555555, 32'h5555_5555, 1, 1'b0, 1'b0, '0);
        add_vec(salc_pkg::FUNC_WRITE, 8'hFF, 24'h123456, 32'h1234_5678, 0, 1'b0, 1'b0, '0);
        add_vec(salc_pkg::FUNC_READ,  8'hFF, 24'hABCDEF, 32'hABCD_EF01, 0, 1'b0, 1'b0, '0);
        add_vec(salc_pkg::FUNC_READ,  8'hFF, 24'hAAAAAA, 32'h0000_0000, 0, 1'b0, 1'b0, '0);
        add_vec(salc_pkg::FUNC_WRITE, 8'hFF, 24'h0F0F0F, 32'h0F0F_0F0F, 0, 1'b0, 1'b0, '0);
        // A tag already held in set 0 must miss in an untouched set.
        add_vec(salc_pkg::FUNC_READ,  8'h80, 24'h000000, 32'h8000_0000, 1, 1'b0, 1'b0, '0);
        add_vec(salc_pkg::FUNC_WRITE, 8'h01, 24'hFFFFFF, 32'h7FFF_FFFF, 1, 1'b0, 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_reqs[i]) begin
            send_req(directed_reqs[i].req, directed_reqs[i].known, directed_reqs[i].rsp);
            n_directed++;
        end

        for (int n = 0; n < RANDOM_REQS; n++) begin
            // At regular points, choose at random between stretches with random gaps and gap-free bursts.
            if (n % BURST_EVERY == 0) burst_mode = (($urandom_range(0, 2)) == 0);
            // Ask the response side for one long stall while requests keep
            // arriving, so the tag store fills up and stalls its input.
            if (n == HOLD_AT) hold_requested = 1'b1;
            // Once, let the tag store drain completely before going on.
            if (n == PAUSE_AT) begin
                @(negedge i_clk);
                i_req_valid <= 1'b0;
                while (pending_rsp.size() != 0) @(posedge i_clk);
            end
            r = random_req();
            send_req(r, 1'b0, none);
            n_random++;
        end
        @(negedge i_clk);
        i_req_valid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge i_clk);
        // Keep the clock running so that any spurious late response is caught.
        wait_cycles = DRAIN_CYCLES;
        repeat (wait_cycles) @(posedge i_clk);

        $display("Ran %0d directed and %0d random requests; %0d responses checked.",
                 n_directed, n_random, n_checked);
        $display("Responses included %0d hits and %0d dirty-line writebacks.",
                 n_hits, n_writebacks);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire
